// File: src/ddeo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential drive odometry package
// Shared types, codes and default sizes for the wheel odometry block.
// ----------------------------------------------------------------------------
package ddeo_pkg;

	localparam int TICK_SUM_WIDTH_DEF = 24;
	localparam int ACCUM_WIDTH_DEF    = 48;
	localparam int FRAC_BITS_DEF      = 16;
	localparam int COUNTER_WIDTH_DEF  = 16;

	localparam int GAIN_WIDTH = 24;
	localparam int MUL_A_WIDTH = 32;
	localparam int ADDR_WIDTH = 4;
	localparam int DATA_WIDTH = 32;

	localparam logic [GAIN_WIDTH-1:0] LEFT_GAIN_RESET  = 24'd17086;
	localparam logic [GAIN_WIDTH-1:0] RIGHT_GAIN_RESET = 24'd15459;
	localparam logic [GAIN_WIDTH-1:0] DEG_GAIN_RESET   = 24'd48041;

	localparam logic [1:0] OP_RIGHT  = 2'd0;
	localparam logic [1:0] OP_LEFT   = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	localparam logic [1:0] REG_LEFT_GAIN  = 2'd0;
	localparam logic [1:0] REG_RIGHT_GAIN = 2'd1;
	localparam logic [1:0] REG_DEG_GAIN   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_R,
		ST_MUL_L,
		ST_SUMS,
		ST_ABS,
		ST_MUL_DLO,
		ST_MUL_DHI,
		ST_COMBINE,
		ST_SAT_ROT,
		ST_FINISH
	} state_t;

endpackage

// File: src/diff_drive_encoder_odometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential drive encoder odometry
// Wheel tick accumulation and fixed point odometry update on a shared
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall with op and count. A right or left
// capture request is taken while the sequencer is idle, so captures can
// arrive back to back. An update request runs through nine sequencer
// steps: the single 32 x 24 multiplier is used four times (two wheel
// distances, then the low and high halves of the rotation product), with
// adds, magnitudes and saturation in the steps between. in_stall is high
// until the sequencer is idle again; out_valid rises after the last step.
// If the receiver stalls, captures are still accepted; a following update
// holds in its last step until the pending result has been taken. The user
// must write the gains through the APB port only while the block is idle;
// the block does not enforce this. Reads return the stored value. Reset
// restores default gains and clears tick sums, last counts, totals, out_valid.
// ----------------------------------------------------------------------------
module diff_drive_encoder_odometry
	import ddeo_pkg::*;
#(
	parameter int TICK_SUM_WIDTH = TICK_SUM_WIDTH_DEF,
	parameter int ACCUM_WIDTH    = ACCUM_WIDTH_DEF,
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int COUNTER_WIDTH  = COUNTER_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic [COUNTER_WIDTH-1:0]      count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [ACCUM_WIDTH-1:0] position_mm,
	output logic signed [ACCUM_WIDTH-1:0] heading_deg,
	output logic signed [ACCUM_WIDTH-1:0] forward_step,
	output logic signed [ACCUM_WIDTH-1:0] rotation_step,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_WIDTH-1:0]         paddr,
	input  logic [DATA_WIDTH-1:0]         pwdata,
	output logic [DATA_WIDTH-1:0]         prdata,
	output logic                          pready
);

	localparam int T     = TICK_SUM_WIDTH;
	localparam int A     = ACCUM_WIDTH;
	localparam int C     = COUNTER_WIDTH;
	localparam int G     = GAIN_WIDTH;
	localparam int PW    = T + G + 1;
	localparam int SW    = PW + 1;
	localparam int PRODW = MUL_A_WIDTH + G;
	localparam int FULLW = PRODW + MUL_A_WIDTH;
	localparam int RMW   = FULLW - FRAC_BITS;
	localparam int SATW  = ((RMW > A) ? RMW : A) + 1;
	localparam int SUMW  = ((T > C) ? T : C) + 2;

	localparam logic signed [SUMW-1:0] TICK_MAX = {{(SUMW-T+1){1'b0}}, {(T-1){1'b1}}};
	localparam logic signed [SUMW-1:0] TICK_MIN = {{(SUMW-T+1){1'b1}}, {(T-1){1'b0}}};
	localparam logic [SATW-1:0] SAT_MAXPOS = SATW'({1'b0, {(A-1){1'b1}}});
	localparam logic [SATW-1:0] SAT_MINMAG = SATW'({1'b1, {(A-1){1'b0}}});

	state_t state_q, state_d;

	logic [G-1:0] left_gain_q, right_gain_q, deg_gain_q;
	logic [C-1:0] right_last_q, left_last_q;
	logic signed [T-1:0] rsum_q, lsum_q;
	logic [A-1:0] pos_total_q, head_total_q;
	logic out_valid_q;
	logic [A-1:0] fwd_out_q, rot_out_q;

	logic [PRODW-1:0] prod_q, lo_q;
	logic rneg_q, lneg_q, dneg_q, fneg_q;
	logic signed [PW-1:0] rd_q;
	logic signed [SW-1:0] s_q, d_q;
	logic [SW-1:0] dmag_q;
	logic [SW-2:0] fmag_q;
	logic [RMW-1:0] rmag_q;
	logic [A-1:0] fwd_q, rot_q;

	logic in_accept, cfg_write, out_free, finish_fire;
	logic [C-1:0] sel_last, diff_raw;
	logic signed [T-1:0] sel_sum, cap_sat;
	logic signed [SUMW-1:0] cap_wide;
	logic [T-1:0] rmag_t, lmag_t;
	logic [MUL_A_WIDTH-1:0] mul_a;
	logic [G-1:0] mul_b;
	logic [PRODW-1:0] mul_p;
	logic [PW-1:0] prod_ext;
	logic signed [PW-1:0] ld;
	logic [SW-1:0] dmag, smag;
	logic [FULLW-1:0] full;
	logic [SATW-1:0] sat_mag, sat_lim, sat_clip;
	logic sat_neg;
	logic [A-1:0] sat_res;

	assign in_accept   = in_valid && !in_stall;
	assign cfg_write   = psel && penable && pwrite && pready;
	assign out_free    = !out_valid_q || !out_stall;
	assign finish_fire = (state_q == ST_FINISH) && out_free;
	assign pready      = 1'b1;

	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && op == OP_UPDATE) begin
					state_d = ST_MUL_R;
				end
			end
			ST_MUL_R:   state_d = ST_MUL_L;
			ST_MUL_L:   state_d = ST_SUMS;
			ST_SUMS:    state_d = ST_ABS;
			ST_ABS:     state_d = ST_MUL_DLO;
			ST_MUL_DLO: state_d = ST_MUL_DHI;
			ST_MUL_DHI: state_d = ST_COMBINE;
			ST_COMBINE: state_d = ST_SAT_ROT;
			ST_SAT_ROT: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		sel_sum  = (op == OP_LEFT) ? lsum_q : rsum_q;
		sel_last = (op == OP_LEFT) ? left_last_q : right_last_q;
		diff_raw = count - sel_last;
		cap_wide = SUMW'(sel_sum) - SUMW'($signed(diff_raw));
		if (cap_wide > TICK_MAX) begin
			cap_sat = TICK_MAX[T-1:0];
		end else if (cap_wide < TICK_MIN) begin
			cap_sat = TICK_MIN[T-1:0];
		end else begin
			cap_sat = cap_wide[T-1:0];
		end
	end

	always_comb begin
		rmag_t = rsum_q[T-1] ? $unsigned(~rsum_q + 1'b1) : $unsigned(rsum_q);
		lmag_t = lsum_q[T-1] ? $unsigned(~lsum_q + 1'b1) : $unsigned(lsum_q);
		unique case (state_q)
			ST_MUL_R:   mul_a = MUL_A_WIDTH'(rmag_t);
			ST_MUL_L:   mul_a = MUL_A_WIDTH'(lmag_t);
			ST_MUL_DLO: mul_a = dmag_q[MUL_A_WIDTH-1:0];
			ST_MUL_DHI: mul_a = MUL_A_WIDTH'(dmag_q[SW-1:MUL_A_WIDTH]);
			default:    mul_a = '0;
		endcase
		unique case (state_q)
			ST_MUL_R: mul_b = right_gain_q;
			ST_MUL_L: mul_b = left_gain_q;
			default:  mul_b = deg_gain_q;
		endcase
		mul_p = PRODW'(mul_a) * PRODW'(mul_b);
	end

	always_comb begin
		prod_ext = PW'(prod_q);
		ld   = lneg_q ? $signed(~prod_ext + 1'b1) : $signed(prod_ext);
		dmag = d_q[SW-1] ? $unsigned(~d_q + 1'b1) : $unsigned(d_q);
		smag = s_q[SW-1] ? $unsigned(~s_q + 1'b1) : $unsigned(s_q);
		full = {prod_q, {MUL_A_WIDTH{1'b0}}} + FULLW'(lo_q);
	end

	always_comb begin
		if (state_q == ST_SAT_ROT) begin
			sat_mag = SATW'(rmag_q);
			sat_neg = dneg_q;
		end else begin
			sat_mag = SATW'(fmag_q);
			sat_neg = fneg_q;
		end
		sat_lim  = sat_neg ? SAT_MINMAG : SAT_MAXPOS;
		sat_clip = (sat_mag > sat_lim) ? sat_lim : sat_mag;
		sat_res  = sat_neg ? (~sat_clip[A-1:0] + 1'b1) : sat_clip[A-1:0];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_MUL_R: begin
				prod_q <= mul_p;
				rneg_q <= rsum_q[T-1];
			end
			ST_MUL_L: begin
				prod_q <= mul_p;
				lneg_q <= lsum_q[T-1];
				rd_q   <= rneg_q ? $signed(~prod_ext + 1'b1) : $signed(prod_ext);
			end
			ST_SUMS: begin
				s_q <= SW'(rd_q) + SW'(ld);
				d_q <= SW'(rd_q) - SW'(ld);
			end
			ST_ABS: begin
				dmag_q <= dmag;
				dneg_q <= d_q[SW-1];
				fmag_q <= smag[SW-1:1];
				fneg_q <= s_q[SW-1];
			end
			ST_MUL_DLO: begin
				prod_q <= mul_p;
				fwd_q  <= sat_res;
			end
			ST_MUL_DHI: begin
				prod_q <= mul_p;
				lo_q   <= prod_q;
			end
			ST_COMBINE: rmag_q <= full[FULLW-1:FRAC_BITS];
			ST_SAT_ROT: rot_q <= sat_res;
			default: begin
			end
		endcase
		if (finish_fire) begin
			fwd_out_q <= fwd_q;
			rot_out_q <= rot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_gain_q  <= LEFT_GAIN_RESET;
			right_gain_q <= RIGHT_GAIN_RESET;
			deg_gain_q   <= DEG_GAIN_RESET;
			right_last_q <= '0;
			left_last_q  <= '0;
			rsum_q       <= '0;
			lsum_q       <= '0;
			pos_total_q  <= '0;
			head_total_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (paddr[3:2])
					REG_LEFT_GAIN:  left_gain_q  <= pwdata[G-1:0];
					REG_RIGHT_GAIN: right_gain_q <= pwdata[G-1:0];
					REG_DEG_GAIN:   deg_gain_q   <= pwdata[G-1:0];
					default: begin
					end
				endcase
			end
			if (in_accept && op == OP_RIGHT) begin
				rsum_q       <= cap_sat;
				right_last_q <= count;
			end
			if (in_accept && op == OP_LEFT) begin
				lsum_q      <= cap_sat;
				left_last_q <= count;
			end
			if (state_q == ST_MUL_R) begin
				rsum_q <= '0;
			end
			if (state_q == ST_MUL_L) begin
				lsum_q <= '0;
			end
			if (finish_fire) begin
				pos_total_q  <= pos_total_q + fwd_q;
				head_total_q <= head_total_q + rot_q;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LEFT_GAIN:  prdata = DATA_WIDTH'(left_gain_q);
			REG_RIGHT_GAIN: prdata = DATA_WIDTH'(right_gain_q);
			REG_DEG_GAIN:   prdata = DATA_WIDTH'(deg_gain_q);
			default:        prdata = '0;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign position_mm   = $signed(pos_total_q);
	assign heading_deg   = $signed(head_total_q);
	assign forward_step  = $signed(fwd_out_q);
	assign rotation_step = $signed(rot_out_q);

	a_update_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && op == OP_UPDATE) |=> in_stall)
		else $error("update request did not start the sequencer");

	a_right_keeps_left: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && op == OP_RIGHT) |=> $stable(lsum_q))
		else $error("right capture changed the left tick sum");

	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_L) |=> (rsum_q == '0 && lsum_q == '0))
		else $error("tick sums not cleared by update");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the final step");

endmodule
